// ----- rtl/sliding_median_filter_macros.svh -----
// Assertion macros used by the sliding median filter top level.
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SMF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/smf_pkg.sv -----
// Package with types, constants and helpers for the sliding median filter.
package smf_pkg;

   localparam int MAX_WINDOW = 15;
   localparam int SAMPLE_W   = 16;
   localparam int CFG_W      = 4;
   localparam int IDX_W      = $clog2(MAX_WINDOW + 1);
   localparam int LAG_W      = $clog2(MAX_WINDOW / 2 + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [LAG_W-1:0]           lag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_RANK,
      ST_EMIT
   } smf_state_type;

   // Controls from the sequencer to the cell row and output stage
   typedef struct packed {
      logic    push;
      logic    push_zero;
      logic    clear;
      logic    rank_en;
      idx_type probe_idx;
      logic    out_load;
      logic    out_end;
   } smf_ctl_type;

   // Effective window length: zero acts as one, clipped to the maximum
   function automatic idx_type eff_len(input logic [CFG_W-1:0] wl);
      idx_type m;
      if (wl == '0) begin
         m = idx_type'(1);
      end else if (int'(wl) > MAX_WINDOW) begin
         m = idx_type'(MAX_WINDOW);
      end else begin
         m = idx_type'(wl);
      end
      return m;
   endfunction

   // Output lag, M - 1 - (M - 1) / 2, which equals M / 2
   function automatic lag_type lag_of(input idx_type m);
      return lag_type'(m >> 1);
   endfunction

endpackage

// ----- rtl/smf_cell.sv -----
// One window cell: holds a sample, shifts it on, and counts its rank.
module smf_cell import smf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  smf_ctl_type ctl,
   input  idx_type     cell_idx,
   input  sample_type  shift_in,
   input  sample_type  probe,
   output sample_type  sample,
   output idx_type     rank
);

   sample_type sample_ff;
   idx_type    rank_ff;
   idx_type    rank_in;
   logic       less;

   // Probe ranks below this cell on smaller value, or equal value at a lower slot
   always_comb begin
      less = (probe < sample_ff) || ((probe == sample_ff) && (ctl.probe_idx < cell_idx));
      rank_in = ((ctl.probe_idx == '0) ? '0 : rank_ff) + idx_type'(less);
   end

   // Sample register: cleared at end of run, shifted on push
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctl.clear) begin
         sample_ff <= '0;
      end else if (ctl.push) begin
         sample_ff <= shift_in;
      end
   end

   // Rank counter, restarted by the first probe
   always_ff @(posedge clock) begin
      if (ctl.rank_en) begin
         rank_ff <= rank_in;
      end
   end

   assign sample = sample_ff;
   assign rank   = rank_ff;

endmodule

// ----- rtl/smf_select.sv -----
// Picks the middle-ranked cells and forms the median.
module smf_select import smf_pkg::*; (
   input  sample_type            samples [MAX_WINDOW],
   input  idx_type               ranks   [MAX_WINDOW],
   input  idx_type               win_len,
   output sample_type            median,
   output logic [MAX_WINDOW-1:0] hit_hi
);

   idx_type                   k_hi;
   idx_type                   k_lo;
   sample_type                val_hi;
   sample_type                val_lo;
   logic signed [SAMPLE_W:0]  pair_sum;
   logic signed [SAMPLE_W:0]  pair_adj;

   // Or-reduce the values of the active cells holding the wanted ranks
   always_comb begin
      k_hi   = win_len >> 1;
      k_lo   = k_hi - idx_type'(1);
      val_hi = '0;
      val_lo = '0;
      hit_hi = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (idx_type'(i) < win_len) begin
            if (ranks[i] == k_hi) begin
               hit_hi[i] = 1'b1;
               val_hi    = val_hi | samples[i];
            end
            if (ranks[i] == k_lo) begin
               val_lo = val_lo | samples[i];
            end
         end
      end
   end

   // Odd length: middle value; even: mean of the pair, truncated towards zero
   always_comb begin
      pair_sum = {val_hi[SAMPLE_W-1], val_hi} + {val_lo[SAMPLE_W-1], val_lo};
      pair_adj = pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W]);
      if (win_len[0]) begin
         median = val_hi;
      end else begin
         median = pair_adj[SAMPLE_W:1];
      end
   end

endmodule

// ----- rtl/smf_ctrl.sv -----
// Sequencer: lead count, flush steps, rank sweep and result hand-off.
module smf_ctrl import smf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  idx_type     win_len,
   input  logic        in_valid,
   input  logic        in_last,
   input  logic        out_free,
   output logic        in_ready,
   output smf_ctl_type ctl
);

   smf_state_type state_ff, state_in;
   lag_type       lead_ff, lead_in;
   lag_type       step_ff, step_in;
   lag_type       skip_ff, skip_in;
   logic          flush_ff, flush_in;
   logic          end_ff, end_in;
   idx_type       probe_ff, probe_in;
   lag_type       lag;
   lag_type       lead_cap;

   assign lag      = lag_of(win_len);
   assign lead_cap = (lead_ff > lag) ? lag : lead_ff;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lead_ff  <= '0;
         step_ff  <= '0;
         skip_ff  <= '0;
         flush_ff <= 1'b0;
         end_ff   <= 1'b0;
         probe_ff <= '0;
      end else begin
         state_ff <= state_in;
         lead_ff  <= lead_in;
         step_ff  <= step_in;
         skip_ff  <= skip_in;
         flush_ff <= flush_in;
         end_ff   <= end_in;
         probe_ff <= probe_in;
      end
   end

   // Next state and controls
   always_comb begin
      state_in = state_ff;
      lead_in  = lead_ff;
      step_in  = step_ff;
      skip_in  = skip_ff;
      flush_in = flush_ff;
      end_in   = end_ff;
      probe_in = probe_ff;
      in_ready = 1'b0;
      ctl      = '0;
      ctl.probe_idx = probe_ff;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               ctl.push = 1'b1;
               if (!in_last) begin
                  if (lead_ff < lag) begin
                     lead_in = lead_ff + lag_type'(1);
                  end else begin
                     end_in   = 1'b0;
                     flush_in = 1'b0;
                     probe_in = '0;
                     state_in = ST_RANK;
                  end
               end else begin
                  // Older pending outputs beyond lag+1 are dropped
                  flush_in = 1'b1;
                  step_in  = '0;
                  skip_in  = lag - lead_cap;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (step_ff >= skip_ff) begin
               end_in   = (step_ff == lag);
               probe_in = '0;
               state_in = ST_RANK;
            end else begin
               step_in       = step_ff + lag_type'(1);
               ctl.push      = 1'b1;
               ctl.push_zero = 1'b1;
            end
         end
         ST_RANK: begin
            ctl.rank_en = 1'b1;
            if (probe_ff == win_len - idx_type'(1)) begin
               state_in = ST_EMIT;
            end else begin
               probe_in = probe_ff + idx_type'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_end  = end_ff;
               if (!flush_ff) begin
                  state_in = ST_IDLE;
               end else if (step_ff == lag) begin
                  ctl.clear = 1'b1;
                  lead_in   = '0;
                  flush_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  step_in       = step_ff + lag_type'(1);
                  ctl.push      = 1'b1;
                  ctl.push_zero = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/sliding_median_filter.sv -----
// Top level of the sliding median filter: cell row, sequencer, output register.
//
//   channel  dir  words carried
//   req_     in   sample in tdata, last-of-run in tlast
//   rsp_     out  median in tdata, end of run in tlast
//   csr_     in   window length write, no read-back
//
// A word still filling the lag is only accepted and shifted in. A word that yields a
// median is accepted, then runs M rank-sweep steps over the cell row, then is emitted.
// A last word releases up to L + 1 medians, L = M / 2, through zero-padding
// flush steps, each released median running a full rank sweep.
// Reset clears the window, lead count and handshakes; window length returns to 3.
// A stalled rsp_ holds its word; req_ keeps being accepted while it waits,
// until the next median is ready to load.
`include "sliding_median_filter_macros.svh"
module sliding_median_filter import smf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // [15:0] sample
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] median
   output logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0]      window_len_ff;
   idx_type               win_len;
   smf_ctl_type           ctl;
   logic                  out_free;
   sample_type            push_val;
   sample_type            probe;
   sample_type            samples [MAX_WINDOW];
   idx_type               ranks   [MAX_WINDOW];
   sample_type            median;
   logic [MAX_WINDOW-1:0] hit_hi;
   logic                  rsp_valid_ff;
   sample_type            rsp_data_ff;
   logic                  rsp_last_ff;

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= CFG_W'(3);
      end else if (csr_wr_en) begin
         window_len_ff <= csr_wr_data;
      end
   end

   assign win_len  = eff_len(window_len_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign push_val = ctl.push_zero ? '0 : sample_type'(req_tdata);
   assign probe    = samples[ctl.probe_idx];

   smf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .win_len  (win_len),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .out_free (out_free),
      .in_ready (req_tready),
      .ctl      (ctl)
   );

   // Row of cells, newest sample in cell 0
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      smf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cell_idx (idx_type'(g)),
         .shift_in ((g == 0) ? push_val : samples[(g == 0) ? 0 : g - 1]),
         .probe    (probe),
         .sample   (samples[g]),
         .rank     (ranks[g])
      );
   end

   smf_select u_select (
      .samples (samples),
      .ranks   (ranks),
      .win_len (win_len),
      .median  (median),
      .hit_hi  (hit_hi)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_data_ff <= median;
         rsp_last_ff <= ctl.out_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `SMF_ASSERT_IMP(a_one_median, clock, reset, ctl.out_load, $onehot(hit_hi), "median rank not unique")
   `SMF_ASSERT_IMP(a_rank_busy, clock, reset, ctl.rank_en, !req_tready, "input ready during rank sweep")
   `SMF_ASSERT_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input ready after last word")
   `SMF_ASSERT_IMP(a_load_free, clock, reset, ctl.out_load, out_free, "result loaded over a waiting word")

endmodule

// ----- tb/tb_sliding_median_filter.sv -----
// Self-checking testbench for the sliding median filter: prediction, stimulus and checks.
module tb_sliding_median_filter import smf_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_WORDS = 120;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      sample_type sample;
      logic       last;
   } sample_word_type;

   typedef struct {
      sample_type median;
      logic       end_of_run;
   } median_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [15:0]      req_tdata = '0;   // [15:0] sample
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [15:0]      rsp_tdata;        // [15:0] median
   logic             rsp_tlast;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   sliding_median_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus and expectation stores
   sample_word_type  word_q[$];
   median_word_type  median_q[$];
   int unsigned      fail_cnt = 0;
   int unsigned      cycle_cnt = 0;
   bit               no_idle = 1'b0;
   int               req_gap = 0;
   int               rsp_hold = 0;

   // Filter state as predicted: newest sample first
   sample_type       filt_win [MAX_WINDOW];
   int               filt_lead = 0;
   logic [CFG_W-1:0] filt_len = CFG_W'(3);

   initial begin
      foreach (filt_win[i]) begin
         filt_win[i] = '0;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_idle();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   function automatic void shift_in(sample_type s);
      for (int i = MAX_WINDOW - 1; i > 0; i--) begin
         filt_win[i] = filt_win[i-1];
      end
      filt_win[0] = s;
   endfunction

   // Median of the m newest samples; even m averages the middle pair toward zero
   function automatic sample_type median_of_window(int m);
      int srt [MAX_WINDOW];
      int v;
      int j;
      for (int i = 0; i < m; i++) begin
         v = filt_win[i];
         j = i;
         while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = v;
      end
      if (m % 2 == 1) begin
         return sample_type'(srt[m/2]);
      end
      return sample_type'((srt[m/2-1] + srt[m/2]) / 2);
   endfunction

   // Works out the medians that one accepted word releases
   function automatic void predict_medians(sample_type s, logic last);
      int m;
      int lag;
      int pending;
      median_word_type w;
      m = (filt_len == '0) ? 1 : int'(filt_len);
      if (m > MAX_WINDOW) begin
         m = MAX_WINDOW;
      end
      lag = m - 1 - (m - 1) / 2;
      shift_in(s);
      if (!last) begin
         if (filt_lead < lag) begin
            filt_lead++;
         end else begin
            w.median = median_of_window(m);
            w.end_of_run = 1'b0;
            median_q.insert(median_q.size(), w);
         end
      end else begin
         // flush with zero padding; only the newest lag+1 pending medians survive
         pending = filt_lead + 1;
         if (pending > lag + 1) begin
            pending = lag + 1;
         end
         for (int t = 0; t <= lag; t++) begin
            if (t > 0) begin
               shift_in('0);
            end
            if (t >= lag + 1 - pending) begin
               w.median = median_of_window(m);
               w.end_of_run = (t == lag);
               median_q.insert(median_q.size(), w);
            end
         end
         foreach (filt_win[i]) begin
            filt_win[i] = '0;
         end
         filt_lead = 0;
      end
   endfunction

   function automatic void note_failure();
      fail_cnt++;
   endfunction

   // Input driver: one word per handshake, random gaps between words
   always @(posedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (word_q.size() != 0) begin
            w = word_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= w.sample;
            req_tlast <= w.last;
            req_gap = pick_idle();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = pick_idle();
      end
   end

   // Monitor: check results against the oldest expectation, then predict
   always @(posedge clock) begin
      median_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (median_q.size() == 0) begin
               note_failure();
               if (fail_cnt <= MAX_REPORTS) begin
                  $display("%0t: unexpected word: median %0d end %0b", $time,
                           $signed(rsp_tdata), rsp_tlast);
               end
            end else begin
               want = median_q.pop_front();
               if (rsp_tdata !== want.median) begin
                  note_failure();
                  if (fail_cnt <= MAX_REPORTS) begin
                     $display("%0t: median expected %0d actual %0d", $time,
                              want.median, $signed(rsp_tdata));
                  end
               end
               if (rsp_tlast !== want.end_of_run) begin
                  note_failure();
                  if (fail_cnt <= MAX_REPORTS) begin
                     $display("%0t: end of run expected %0b actual %0b", $time,
                              want.end_of_run, rsp_tlast);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_medians(sample_type'(req_tdata), req_tlast);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void queue_word(int s, logic last);
      sample_word_type w;
      w.sample = sample_type'(s);
      w.last = last;
      word_q.insert(word_q.size(), w);
   endfunction

   // Extremes, small values with ties, or anything
   function automatic int rand_sample();
      int r;
      r = $urandom_range(3);
      if (r == 0) begin
         case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return -1;
            default: return 0;
         endcase
      end
      if (r == 1) begin
         return $urandom_range(8) - 4;
      end
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic logic [CFG_W-1:0] pick_len();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'(2);
            default: return CFG_W'(MAX_WINDOW);
         endcase
      end
      return CFG_W'($urandom_range(15));
   endfunction

   // Wait until every word is sent and every median has come, then let the block settle
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (word_q.size() != 0 || req_tvalid || median_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_len(logic [CFG_W-1:0] v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      filt_len = v;
      @(negedge clock);
   endtask

   initial begin
      int rand_words;
      int n_runs;
      int run_len;
      bit close;
      rand_words = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length of 3: extremes, then a one-word run that ends before the lag is filled
      queue_word(32767, 1'b0);
      queue_word(-32768, 1'b0);
      queue_word(32767, 1'b0);
      queue_word(-1, 1'b1);
      queue_word(-32768, 1'b1);

      // zero length behaves as one
      write_len('0);
      queue_word(5, 1'b0);
      queue_word(-5, 1'b0);
      queue_word(-32768, 1'b1);

      // longest window: short run, then an open run that leaves medians pending
      write_len(CFG_W'(MAX_WINDOW));
      queue_word(7, 1'b0);
      queue_word(7, 1'b0);
      queue_word(-32768, 1'b1);
      queue_word(32767, 1'b0);
      queue_word(1, 1'b0);
      queue_word(1, 1'b0);
      queue_word(-2, 1'b0);
      queue_word(32767, 1'b0);

      // shrink mid-run: lead above the new lag, flush drops older pending medians
      write_len(CFG_W'(2));
      queue_word(1234, 1'b0);
      queue_word(-1234, 1'b1);

      // even window, middle pair averaged with truncation toward zero
      write_len(CFG_W'(4));
      queue_word(-3, 1'b0);
      queue_word(-4, 1'b0);
      queue_word(7, 1'b0);
      queue_word(-32768, 1'b1);

      // random phases, each with its own window length; some runs left open
      while (rand_words < RANDOM_WORDS) begin
         write_len(pick_len());
         no_idle = ($urandom_range(3) == 0);
         n_runs = $urandom_range(4, 1);
         for (int r = 0; r < n_runs; r++) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
            close = (r < n_runs - 1) || ($urandom_range(4) != 0);
            for (int k = 0; k < run_len; k++) begin
               queue_word(rand_sample(), close && (k == run_len - 1));
            end
            rand_words += run_len;
         end
      end

      // close any open run so its medians come out, then drain
      no_idle = 1'b0;
      queue_word(rand_sample(), 1'b1);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0 && median_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/smf_select.sv
rtl/smf_ctrl.sv
rtl/sliding_median_filter.sv
tb/tb_sliding_median_filter.sv
